// File: hw/rtl/fpr_pkg.sv
// Shared types and constants for the framed payload receiver.
`timescale 1ns / 1ps
package fpr_pkg;

	localparam int NUM_CODES = 8;
	localparam int CODE_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int SEL_W = 4;

	localparam int PAYLOAD_DEPTH_DEF = 256;
	localparam int CHECK_DEPTH_DEF = 16;

	// Match select codes, in priority order; SEL_DATA means no code matched.
	localparam logic [SEL_W-1:0] SEL_PING          = 4'd0;
	localparam logic [SEL_W-1:0] SEL_PONG          = 4'd1;
	localparam logic [SEL_W-1:0] SEL_ESCAPE        = 4'd2;
	localparam logic [SEL_W-1:0] SEL_REQUEST_SEND  = 4'd3;
	localparam logic [SEL_W-1:0] SEL_BEGIN_PAYLOAD = 4'd4;
	localparam logic [SEL_W-1:0] SEL_END_PAYLOAD   = 4'd5;
	localparam logic [SEL_W-1:0] SEL_BEGIN_CHECK   = 4'd6;
	localparam logic [SEL_W-1:0] SEL_END_CHECK     = 4'd7;
	localparam logic [SEL_W-1:0] SEL_DATA          = 4'd8;

	// Reply kinds.
	localparam logic [1:0] KIND_PONG   = 2'd0;
	localparam logic [1:0] KIND_REFUSE = 2'd1;
	localparam logic [1:0] KIND_CTS    = 2'd2;
	localparam logic [1:0] KIND_OK     = 2'd3;

	// Store targets.
	localparam logic TARGET_PAYLOAD = 1'b0;
	localparam logic TARGET_CHECK   = 1'b1;

	typedef struct packed {
		logic       reply_valid;
		logic [1:0] reply_kind;
		logic       fault;
		logic       unhandled;
		logic       pong_seen;
		logic       frame_done;
		logic       store_valid;
		logic       store_target;
		logic [7:0] store_index;
		logic [7:0] store_data;
	} result_t;

endpackage

// File: hw/rtl/framed_payload_receiver.sv
// Top level of the framed payload receiver: input and result registers.
`timescale 1ns / 1ps
// One received byte per word in, one result word out. The block takes a word
// every cycle while the result register drains; each word goes from the input
// register through the decoder into the result register, held there until
// taken. The decoder's state update settles one word per cycle while the
// pipeline advances. The user must write control codes (cfg_we/cfg_index/
// cfg_data) only while idle, which the block does not enforce; reset loads
// codes 1..8. Store strobes address an external payload or checksum memory.
module framed_payload_receiver #(
	parameter int PAYLOAD_DEPTH = fpr_pkg::PAYLOAD_DEPTH_DEF,
	parameter int CHECK_DEPTH   = fpr_pkg::CHECK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpr_pkg::CODE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          reply_valid,
	output logic [1:0]                    reply_kind,
	output logic                          fault,
	output logic                          unhandled,
	output logic                          pong_seen,
	output logic                          frame_done,
	output logic                          store_valid,
	output logic                          store_target,
	output logic [7:0]                    store_index,
	output logic [7:0]                    store_data
);

	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         valid_s2;
	fpr_pkg::result_t             res_s2;
	fpr_pkg::result_t             res;
	logic [fpr_pkg::SEL_W-1:0]    sel;
	logic                         advance;

	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	fpr_code_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (byte_s1),
		.sel       (sel)
	);

	fpr_decoder #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH),
		.CHECK_DEPTH   (CHECK_DEPTH)
	) u_decoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.sel     (sel),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign reply_valid  = res_s2.reply_valid;
	assign reply_kind   = res_s2.reply_kind;
	assign fault        = res_s2.fault;
	assign unhandled    = res_s2.unhandled;
	assign pong_seen    = res_s2.pong_seen;
	assign frame_done   = res_s2.frame_done;
	assign store_valid  = res_s2.store_valid;
	assign store_target = res_s2.store_target;
	assign store_index  = res_s2.store_index;
	assign store_data   = res_s2.store_data;

endmodule

// File: hw/rtl/fpr_code_match.sv
// Control code registers and priority match of a byte against them.
`timescale 1ns / 1ps
module fpr_code_match (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fpr_pkg::CODE_W-1:0]          cfg_data,
	input  logic [fpr_pkg::CODE_W-1:0]          rx_byte,
	output logic [fpr_pkg::SEL_W-1:0]           sel
);

	logic [fpr_pkg::CODE_W-1:0] codes_q [fpr_pkg::NUM_CODES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fpr_pkg::NUM_CODES; i++) begin
				codes_q[i] <= fpr_pkg::CODE_W'(i + 1);
			end
		end else if (cfg_we) begin
			codes_q[cfg_index] <= cfg_data;
		end
	end

	// Lowest index wins on equal codes.
	always_comb begin
		sel = fpr_pkg::SEL_DATA;
		for (int i = fpr_pkg::NUM_CODES - 1; i >= 0; i--) begin
			if (codes_q[i] == rx_byte) begin
				sel = fpr_pkg::SEL_W'(i);
			end
		end
	end

endmodule

// File: hw/rtl/fpr_decoder.sv
// Receive state and per-word result decode.
`timescale 1ns / 1ps
module fpr_decoder #(
	parameter int PAYLOAD_DEPTH = fpr_pkg::PAYLOAD_DEPTH_DEF,
	parameter int CHECK_DEPTH   = fpr_pkg::CHECK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [fpr_pkg::SEL_W-1:0]   sel,
	input  logic [7:0]                  rx_byte,
	output fpr_pkg::result_t            res
);

	localparam int PAY_CW = $clog2(PAYLOAD_DEPTH + 1);
	localparam int CHK_CW = $clog2(CHECK_DEPTH + 1);

	logic              esc_q, rx_pay_q, rx_chk_q;
	logic [PAY_CW-1:0] pay_cnt_q;
	logic [CHK_CW-1:0] chk_cnt_q;

	logic              esc_d, rx_pay_d, rx_chk_d;
	logic [PAY_CW-1:0] pay_cnt_d;
	logic [CHK_CW-1:0] chk_cnt_d;

	logic busy, do_store, do_fault;

	always_comb begin
		busy      = rx_pay_q | rx_chk_q;
		res       = '0;
		esc_d     = esc_q;
		rx_pay_d  = rx_pay_q;
		rx_chk_d  = rx_chk_q;
		pay_cnt_d = pay_cnt_q;
		chk_cnt_d = chk_cnt_q;
		do_store  = 1'b0;
		do_fault  = 1'b0;

		if (esc_q) begin
			esc_d    = 1'b0;
			do_store = 1'b1;
		end else begin
			case (sel)
				fpr_pkg::SEL_PING: begin
					res.reply_valid = 1'b1;
					res.reply_kind  = fpr_pkg::KIND_PONG;
				end
				fpr_pkg::SEL_PONG: begin
					res.pong_seen = 1'b1;
				end
				fpr_pkg::SEL_ESCAPE: begin
					esc_d = 1'b1;
				end
				fpr_pkg::SEL_REQUEST_SEND: begin
					if (busy) begin
						do_fault = 1'b1;
					end else begin
						res.reply_valid = 1'b1;
						res.reply_kind  = fpr_pkg::KIND_CTS;
					end
				end
				fpr_pkg::SEL_BEGIN_PAYLOAD: begin
					if (busy) begin
						do_fault = 1'b1;
					end else begin
						rx_pay_d  = 1'b1;
						pay_cnt_d = '0;
					end
				end
				fpr_pkg::SEL_END_PAYLOAD: begin
					if (!rx_pay_q) begin
						do_fault = 1'b1;
					end else begin
						rx_pay_d        = 1'b0;
						res.reply_valid = 1'b1;
						res.reply_kind  = fpr_pkg::KIND_OK;
					end
				end
				fpr_pkg::SEL_BEGIN_CHECK: begin
					if (busy) begin
						do_fault = 1'b1;
					end else begin
						rx_chk_d  = 1'b1;
						chk_cnt_d = '0;
					end
				end
				fpr_pkg::SEL_END_CHECK: begin
					if (!rx_chk_q) begin
						do_fault = 1'b1;
					end else begin
						res.reply_valid = 1'b1;
						res.reply_kind  = fpr_pkg::KIND_OK;
						res.frame_done  = 1'b1;
						esc_d           = 1'b0;
						rx_pay_d        = 1'b0;
						rx_chk_d        = 1'b0;
					end
				end
				default: begin
					if (busy) begin
						do_store = 1'b1;
					end else begin
						res.reply_valid = 1'b1;
						res.reply_kind  = fpr_pkg::KIND_REFUSE;
						res.unhandled   = 1'b1;
						esc_d           = 1'b0;
						rx_pay_d        = 1'b0;
						rx_chk_d        = 1'b0;
					end
				end
			endcase
		end

		// Payload takes precedence if both receptions were ever set.
		if (do_store) begin
			if (rx_pay_q) begin
				if (pay_cnt_q >= PAY_CW'(PAYLOAD_DEPTH)) begin
					do_fault = 1'b1;
				end else begin
					res.store_valid  = 1'b1;
					res.store_target = fpr_pkg::TARGET_PAYLOAD;
					res.store_index  = 8'(pay_cnt_q);
					res.store_data   = rx_byte;
					pay_cnt_d        = pay_cnt_q + 1'b1;
				end
			end else if (rx_chk_q) begin
				if (chk_cnt_q >= CHK_CW'(CHECK_DEPTH)) begin
					do_fault = 1'b1;
				end else begin
					res.store_valid  = 1'b1;
					res.store_target = fpr_pkg::TARGET_CHECK;
					res.store_index  = 8'(chk_cnt_q);
					res.store_data   = rx_byte;
					chk_cnt_d        = chk_cnt_q + 1'b1;
				end
			end else begin
				do_fault = 1'b1;
			end
		end

		if (do_fault) begin
			res.reply_valid = 1'b1;
			res.reply_kind  = fpr_pkg::KIND_REFUSE;
			res.fault       = 1'b1;
			esc_d           = 1'b0;
			rx_pay_d        = 1'b0;
			rx_chk_d        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q     <= 1'b0;
			rx_pay_q  <= 1'b0;
			rx_chk_q  <= 1'b0;
			pay_cnt_q <= '0;
			chk_cnt_q <= '0;
		end else if (advance) begin
			esc_q     <= esc_d;
			rx_pay_q  <= rx_pay_d;
			rx_chk_q  <= rx_chk_d;
			pay_cnt_q <= pay_cnt_d;
			chk_cnt_q <= chk_cnt_d;
		end
	end

endmodule
